[src/sfr_pkg.sv]
// Shared types, constants and defaults for the stream find-and-replace block.
package sfr_pkg;

   localparam int PATTERN_MAX_DEF     = 8;
   localparam int REPLACEMENT_MAX_DEF = 8;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int LEN_W      = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_BYTES = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LENGTH = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } sfr_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       string_end;
   } sfr_rsp_type;

   typedef enum logic {
      SFR_IDLE,
      SFR_EMIT
   } sfr_state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic emit;
   } sfr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_full;
      logic item_multi;
      logic emit_final;
   } sfr_status_type;

endpackage

[src/sfr_ctrl.sv]
// Controller state machine: input acceptance and result sequencing.
module sfr_ctrl import sfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic           rsp_stall,
   input  sfr_status_type status,
   output sfr_cmd_type    cmd
);

   sfr_state_type state_ff;
   sfr_state_type state_in;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SFR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output decode
   always_comb begin
      out_free   = !status.out_full || !rsp_stall;
      req_stall  = !((state_ff == SFR_IDLE) && out_free);
      cmd.accept = req_valid && !req_stall;
      cmd.emit   = (state_ff == SFR_EMIT) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SFR_IDLE: begin
            if (cmd.accept && status.item_multi) begin
               state_in = SFR_EMIT;
            end
         end
         SFR_EMIT: begin
            if (cmd.emit && status.emit_final) begin
               state_in = SFR_IDLE;
            end
         end
         default: begin
            state_in = SFR_IDLE;
         end
      endcase
   end

   a_multi_enters_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && status.item_multi |=> state_ff == SFR_EMIT)
      else $error("multi-result transfer did not start emission");

   a_final_leaves_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && status.emit_final |=> state_ff == SFR_IDLE)
      else $error("emission did not end after final result");

endmodule

[src/sfr_dpath.sv]
// Datapath: config registers, prefix match, job registers and result register.
module sfr_dpath import sfr_pkg::*; #(
   parameter int PATTERN_MAX     = PATTERN_MAX_DEF,
   parameter int REPLACEMENT_MAX = REPLACEMENT_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  sfr_req_type           req_data,
   input  sfr_cmd_type           cmd,
   output sfr_status_type        status,
   output logic                  rsp_valid,
   output sfr_rsp_type           rsp_data,
   input  logic                  rsp_stall
);

   localparam int PW = $clog2(PATTERN_MAX + 1);
   localparam int RW = $clog2(REPLACEMENT_MAX + 1);
   localparam int HW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int CW = $clog2(PATTERN_MAX + REPLACEMENT_MAX + 1);

   // configuration
   logic [PATTERN_MAX*8-1:0]     pat_ff, pat_in;
   logic [PW-1:0]                plen_ff, plen_in;
   logic [REPLACEMENT_MAX*8-1:0] rep_ff, rep_in;
   logic [RW-1:0]                rlen_ff, rlen_in;
   logic [LEN_W-1:0]             len_raw;

   // matcher state and job registers
   logic [HW-1:0] match_len_ff, match_len_in;
   logic [HW-1:0] held_ff, held_in;
   logic [7:0]    byte_ff, byte_in;
   logic [PW-1:0] a_ff, a_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          last_ff, last_in;
   logic [CW-1:0] e_ff, e_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sfr_rsp_type   rsp_data_ff, rsp_data_in;

   logic [7:0]             pat_lane [PATTERN_MAX];
   logic [7:0]             rep_lane [REPLACEMENT_MAX];
   logic [7:0]             win      [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] hit;
   logic [PW-1:0]          n, s_sel, keep, a_now;
   logic [RW-1:0]          r_now;
   logic [CW-1:0]          cnt_now;
   logic                   repl;

   logic [CW-1:0] sel_e, sel_cnt;
   logic [PW-1:0] sel_a;
   logic [HW-1:0] sel_held;
   logic [7:0]    sel_byte, ob;
   logic          sel_last, load;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff       <= '0;
         plen_ff      <= '0;
         rep_ff       <= '0;
         rlen_ff      <= '0;
         match_len_ff <= '0;
         e_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_ff       <= pat_in;
         plen_ff      <= plen_in;
         rep_ff       <= rep_in;
         rlen_ff      <= rlen_in;
         match_len_ff <= match_len_in;
         e_ff         <= e_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      byte_ff     <= byte_in;
      a_ff        <= a_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // register writes; lengths saturate on write
   always_comb begin
      pat_in  = pat_ff;
      plen_in = plen_ff;
      rep_in  = rep_ff;
      rlen_in = rlen_ff;
      len_raw = csr_wdata[LEN_W-1:0];
      if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_BYTES: begin
               pat_in = csr_wdata[PATTERN_MAX*8-1:0];
            end
            CSR_PATTERN_LENGTH: begin
               plen_in = (len_raw > LEN_W'(PATTERN_MAX)) ? PW'(PATTERN_MAX) : PW'(len_raw);
            end
            CSR_REPLACEMENT_BYTES: begin
               rep_in = csr_wdata[REPLACEMENT_MAX*8-1:0];
            end
            CSR_REPLACEMENT_LENGTH: begin
               rlen_in = (len_raw > LEN_W'(REPLACEMENT_MAX)) ?
                         RW'(REPLACEMENT_MAX) : RW'(len_raw);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         pat_lane[j] = pat_ff[8*j +: 8];
      end
      for (int j = 0; j < REPLACEMENT_MAX; j++) begin
         rep_lane[j] = rep_ff[8*j +: 8];
      end
   end

   // window = held pattern prefix + new byte; find the earliest start whose
   // tail is still a pattern prefix (KMP-style fallback)
   always_comb begin
      n = PW'(match_len_ff) + PW'(1);
      for (int j = 0; j < PATTERN_MAX; j++) begin
         win[j] = (HW'(j) < match_len_ff) ? pat_lane[j] : req_data.in_byte;
      end
      for (int s = 0; s < PATTERN_MAX; s++) begin
         hit[s] = (PW'(s) < n) && ((n - PW'(s)) <= plen_ff);
         for (int k = 0; k < PATTERN_MAX - s; k++) begin
            if ((PW'(s + k) < n) && (win[s + k] != pat_lane[k])) begin
               hit[s] = 1'b0;
            end
         end
      end
      s_sel = n;
      for (int s = PATTERN_MAX - 1; s >= 0; s--) begin
         if (hit[s]) begin
            s_sel = PW'(s);
         end
      end
      keep    = n - s_sel;
      repl    = (plen_ff != '0) && (keep == plen_ff);
      a_now   = (req_data.in_last && !repl) ? n : s_sel;
      r_now   = repl ? rlen_ff : '0;
      cnt_now = CW'(a_now) + CW'(r_now);
      match_len_in = match_len_ff;
      if (cmd.accept) begin
         match_len_in = (repl || req_data.in_last) ? '0 : HW'(keep);
      end
   end

   // job capture
   always_comb begin
      held_in = held_ff;
      byte_in = byte_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      e_in    = e_ff;
      if (cmd.accept) begin
         held_in = match_len_ff;
         byte_in = req_data.in_byte;
         a_in    = a_now;
         cnt_in  = cnt_now;
         last_in = req_data.in_last;
         e_in    = CW'(1);
      end else if (cmd.emit) begin
         e_in = e_ff + CW'(1);
      end
   end

   // result e: window bytes first, then replacement bytes
   always_comb begin
      sel_e    = cmd.accept ? '0 : e_ff;
      sel_cnt  = cmd.accept ? cnt_now : cnt_ff;
      sel_a    = cmd.accept ? a_now : a_ff;
      sel_held = cmd.accept ? match_len_ff : held_ff;
      sel_byte = cmd.accept ? req_data.in_byte : byte_ff;
      sel_last = cmd.accept ? req_data.in_last : last_ff;
      ob = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if ((sel_e == CW'(j)) && (sel_e < CW'(sel_a))) begin
            ob = (HW'(j) < sel_held) ? pat_lane[j] : sel_byte;
         end
      end
      for (int j = 0; j < REPLACEMENT_MAX; j++) begin
         if ((sel_e >= CW'(sel_a)) && ((sel_e - CW'(sel_a)) == CW'(j))) begin
            ob = rep_lane[j];
         end
      end
      load = (cmd.accept && ((cnt_now != '0) || req_data.in_last)) || cmd.emit;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         if (sel_cnt == '0) begin
            // empty output string: end marker only
            rsp_data_in.out_byte   = '0;
            rsp_data_in.byte_valid = 1'b0;
            rsp_data_in.run_last   = 1'b1;
            rsp_data_in.string_end = 1'b1;
         end else begin
            rsp_data_in.out_byte   = ob;
            rsp_data_in.byte_valid = 1'b1;
            rsp_data_in.run_last   = (sel_e == sel_cnt - CW'(1));
            rsp_data_in.string_end = (sel_e == sel_cnt - CW'(1)) && sel_last;
         end
      end
   end

   always_comb begin
      status.out_full   = rsp_valid_ff;
      status.item_multi = cnt_now > CW'(1);
      status.emit_final = (e_ff == cnt_ff - CW'(1));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> e_ff < cnt_ff)
      else $error("emission ran past the result count");

   a_last_clears_match: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && req_data.in_last |=> match_len_ff == '0)
      else $error("partial match survived end of string");

endmodule

[src/stream_find_and_replace.sv]
// Top level of the streaming find-and-replace block.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  req     | in        | req_valid / req_stall | sfr_req_type: in_byte, in_last
//  rsp     | out       | rsp_valid / rsp_stall | sfr_rsp_type: out_byte, byte_valid,
//          |           |                       |   run_last, string_end
//  csr     | in        | csr_we (no wait)      | csr_index, csr_wdata
//
// A transfer that gives at most one result needs no emission phase; one that
// gives N > 1 results goes out one result per cycle while the output is not
// stalled, as the single result register is loaded once per cycle. The first
// result of a transfer is computed and registered in the cycle of acceptance.
// Reset is synchronous: clears config, partial match, controller and rsp_valid.
// A stalled result holds in its register; req_stall rises only when that
// register cannot be refilled or a burst of results is still going out.
module stream_find_and_replace import sfr_pkg::*; #(
   parameter int PATTERN_MAX     = PATTERN_MAX_DEF,
   parameter int REPLACEMENT_MAX = REPLACEMENT_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // source bytes
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sfr_req_type           req_data,
   // output string
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sfr_rsp_type           rsp_data,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   sfr_cmd_type    cmd;
   sfr_status_type status;

   // sequencing: accept in idle, then walk out any remaining results
   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // match logic, held-prefix tracking and the result register
   sfr_dpath #(
      .PATTERN_MAX     (PATTERN_MAX),
      .REPLACEMENT_MAX (REPLACEMENT_MAX)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
